### hw/rtl/deadline_heap_timer_queue_core_macros.svh
// Assertion macros for the timer queue
`ifndef DEADLINE_HEAP_TIMER_QUEUE_CORE_MACROS_SVH
`define DEADLINE_HEAP_TIMER_QUEUE_CORE_MACROS_SVH
// Assert an implication on the rising clock, off during reset
`define DHTQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dhtq check failed");
// Assert an implication whose consequent is checked in the next cycle
`define DHTQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dhtq check failed");
`endif

### hw/rtl/dhtq_pkg.sv
// Package: default parameters and function and status codes for the timer queue
package dhtq_pkg;
  localparam int DefCapacity = 64;
  localparam int DefIdCount  = 256;
  localparam int DefTimeBits = 32;

  localparam logic [2:0] FUNC_INSERT = 3'd0;
  localparam logic [2:0] FUNC_POLL   = 3'd1;
  localparam logic [2:0] FUNC_REMOVE = 3'd2;
  localparam logic [2:0] FUNC_PEEK   = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NOT_DUE  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_DUP      = 3'd5;
endpackage

### hw/rtl/dhtq_id_table.sv
// Id table: presence bits in flops, slot numbers in a synchronous memory
module dhtq_id_table import dhtq_pkg::*; #(
  parameter int ID_COUNT = DefIdCount,
  parameter int SLOT_BITS = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] rd_id,
  output logic rd_present,
  output logic [SLOT_BITS-1:0] rd_slot,
  input  logic wr_slot_en,
  input  logic [7:0] wr_slot_id,
  input  logic [SLOT_BITS-1:0] wr_slot_val,
  input  logic set_en,
  input  logic clr_en,
  input  logic [7:0] pres_id,
  input  logic clear_all
);
  localparam int IdBits = (ID_COUNT > 256) ? 8 : ((ID_COUNT < 2) ? 1 : $clog2(ID_COUNT));
  localparam int Depth = (ID_COUNT > 256) ? 256 : ID_COUNT;
  logic [Depth-1:0] present;
  logic [SLOT_BITS-1:0] slot_mem [Depth];
  logic [IdBits-1:0] ri, wi, pi;

  assign ri = IdBits'(rd_id);
  assign wi = IdBits'(wr_slot_id);
  assign pi = IdBits'(pres_id);

  always_ff @(posedge clk) begin
    if (wr_slot_en) begin
      slot_mem[wi] <= wr_slot_val;
    end
    rd_slot <= slot_mem[ri];
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      present <= '0;
    end else begin
      if (clr_en) present[pi] <= 1'b0;
      if (set_en) present[pi] <= 1'b1;
    end
  end

  assign rd_present = present[ri];
endmodule

### hw/rtl/deadline_heap_timer_queue_core.sv
// Peek, clear, rejected and empty items pass LOOK, DISP, HEAD, HEADW and OUT after accept.
// Insert lifts one level per pass through UPR and UPD, then writes the entry in SKW.
// Poll and remove sink one level per SKR, SKD and UPD pass and lift one per UPR and UPD pass.
// Throughput: one item in flight; in_stall holds until the result is presented, and the next
// item can be accepted from that same cycle, even while that result is still stalled.
// Reset: queue empty, sequence zero, no clearing pass since heap slots are read only below the held count.
module deadline_heap_timer_queue_core import dhtq_pkg::*; #(
  parameter int CAPACITY  = DefCapacity,
  parameter int ID_COUNT  = DefIdCount,
  parameter int TIME_BITS = DefTimeBits
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] func,
  input  logic [7:0] task_id,
  input  logic [31:0] deadline,
  input  logic [31:0] now_time,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] status,
  output logic [7:0] out_task_id,
  output logic [31:0] out_deadline,
  output logic signed [31:0] head_delay,
  output logic [6:0] entry_count
);
`include "deadline_heap_timer_queue_core_macros.svh"
  localparam int SB = $clog2(CAPACITY);
  localparam int CB = SB + 1;
  localparam int TB = TIME_BITS;
  localparam int EW = TB + 32 + 8;

  localparam logic [3:0] S_IDLE = 4'd0, S_LOOK = 4'd1, S_DISP = 4'd2,
                         S_RDLAST = 4'd3, S_LASTW = 4'd4, S_SKC = 4'd5,
                         S_SKR = 4'd6, S_SKD = 4'd7, S_UPR = 4'd8,
                         S_UPD = 4'd9, S_HEAD = 4'd10, S_HEADW = 4'd11,
                         S_OUT = 4'd12, S_SKW = 4'd13;

  typedef struct packed {
    logic [TB-1:0] dl;
    logic [31:0] sq;
    logic [7:0] tk;
  } ent_t;

  logic [3:0] state;
  logic [EW-1:0] heap_mem [CAPACITY];
  logic [SB-1:0] raddr, waddr;
  logic we;
  ent_t wdata, rdata;
  logic [CB-1:0] held;
  logic [31:0] nseq;
  logic [2:0] f_r, st_r;
  logic [7:0] id_r;
  logic [TB-1:0] dl_r, now_r;
  ent_t cur, cand;
  logic [SB-1:0] k, ch;
  logic up_mode, moved, id_ok;
  logic [7:0] oid;
  logic [31:0] odl;
  logic [TB-1:0] head_gap;
  logic [7:0] look_id;

  // id table
  logic rd_present, ws_en, set_en, clr_en, clear_all;
  logic [SB-1:0] rd_slot, ws_val;
  logic [7:0] ws_id, pres_id;

  // look up the incoming id at accept, then hold the latched one
  assign look_id = (state == S_IDLE) ? task_id : id_r;

  dhtq_id_table #(.ID_COUNT(ID_COUNT), .SLOT_BITS(SB)) u_ids (
    .clk, .rst, .rd_id(look_id), .rd_present, .rd_slot,
    .wr_slot_en(ws_en), .wr_slot_id(ws_id), .wr_slot_val(ws_val),
    .set_en, .clr_en, .pres_id, .clear_all
  );

  always_ff @(posedge clk) begin
    if (we) heap_mem[waddr] <= EW'(wdata);
    rdata <= ent_t'(heap_mem[raddr]);
  end

  function automatic logic ahead(ent_t a, ent_t b);
    logic [TB-1:0] d;
    logic [31:0] s;
    begin
      d = a.dl - b.dl;
      s = a.sq - b.sq;
      ahead = (d != '0) ? d[TB-1] : s[31];
    end
  endfunction

  logic [SB-1:0] par;
  logic [CB:0] lch;
  assign par = (k - SB'(1)) >> 1;
  assign lch = {CB'(k), 1'b1};
  assign head_gap = rdata.dl - now_r;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    logic we_next, ws_en_next, set_en_next, clr_en_next, clear_all_next, out_valid_next;
    we_next = 1'b0; ws_en_next = 1'b0; set_en_next = 1'b0; clr_en_next = 1'b0;
    clear_all_next = 1'b0;
    // hold a result until it is taken
    out_valid_next = out_valid && out_stall;
    if (rst) begin
      state <= S_IDLE; held <= '0; nseq <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          f_r <= func; id_r <= task_id; dl_r <= TB'(deadline); now_r <= TB'(now_time);
          id_ok <= (32'(task_id) < ID_COUNT); raddr <= '0;
          st_r <= ST_OK; oid <= '0; odl <= '0; state <= S_LOOK;
        end
        S_LOOK: begin raddr <= rd_slot; state <= S_DISP; end
        S_DISP: begin
          unique case (f_r)
            FUNC_INSERT:
              if (!id_ok) begin st_r <= ST_NOTFOUND; state <= S_HEAD; end
              else if (rd_present) begin st_r <= ST_DUP; state <= S_HEAD; end
              else if (held >= CB'(CAPACITY)) begin st_r <= ST_FULL; state <= S_HEAD; end
              else begin
                cur <= '{dl: dl_r, sq: nseq, tk: id_r};
                nseq <= nseq + 32'd1; held <= held + CB'(1);
                pres_id <= id_r; set_en_next = 1'b1;
                k <= SB'(held); up_mode <= 1'b1; moved <= 1'b1;
                raddr <= (SB'(held) - SB'(1)) >> 1;
                state <= (held == '0) ? S_SKW : S_UPR;
              end
            FUNC_POLL, FUNC_PEEK:
              if (held == '0) begin st_r <= ST_EMPTY; state <= S_HEAD; end
              else begin
                oid <= rdata.tk; odl <= 32'(rdata.dl);
                if (f_r == FUNC_POLL && head_gap != '0 && !head_gap[TB-1]) begin
                  st_r <= ST_NOT_DUE; state <= S_HEAD;
                end else if (f_r == FUNC_POLL) begin
                  k <= '0; state <= S_RDLAST;
                end else state <= S_HEAD;
              end
            FUNC_REMOVE:
              if (!id_ok || !rd_present || !(CB'(raddr) < held)) begin
                st_r <= ST_NOTFOUND; state <= S_HEAD;
              end else begin k <= raddr; state <= S_RDLAST; end
            FUNC_CLEAR: begin clear_all_next = 1'b1; held <= '0; state <= S_HEAD; end
            default: state <= S_HEAD;
          endcase
        end
        S_RDLAST: begin
          pres_id <= (f_r == FUNC_POLL) ? oid : id_r; clr_en_next = 1'b1;
          held <= held - CB'(1); raddr <= SB'(held - CB'(1));
          state <= (SB'(held - CB'(1)) == k && (held - CB'(1)) == CB'(k)) ? S_HEAD : S_LASTW;
        end
        S_LASTW: begin state <= S_SKC; end
        S_SKC: begin
          cur <= rdata; moved <= 1'b0; up_mode <= 1'b0;
          if (CB'(k) < (held >> 1)) begin raddr <= SB'(lch); state <= S_SKR; end
          else state <= S_SKW;
        end
        S_SKR: begin
          raddr <= SB'(lch + 1); state <= S_SKD;
        end
        S_SKD: begin
          cand <= rdata; ch <= SB'(lch);
          state <= S_UPD;
        end
        S_UPD: begin
          if (!up_mode) begin
            ent_t c; logic [SB-1:0] ci;
            c = cand; ci = ch;
            if ((lch + 1) < {1'b0, held} && !ahead(cand, rdata)) begin
              c = rdata; ci = SB'(lch + 1);
            end
            if (ahead(cur, c)) state <= S_SKW;
            else begin
              we_next = 1'b1; waddr <= k; wdata <= c;
              ws_en_next = 1'b1; ws_id <= c.tk; ws_val <= k;
              k <= ci; moved <= 1'b1;
              if ((CB'(ci) < (held >> 1))) begin
                raddr <= SB'({1'b0, CB'(ci)} * 2 + 1); state <= S_SKR;
              end else state <= S_SKW;
            end
          end else begin
            if (k != '0 && ahead(cur, rdata)) begin
              we_next = 1'b1; waddr <= k; wdata <= rdata;
              ws_en_next = 1'b1; ws_id <= rdata.tk; ws_val <= k;
              k <= par;
              raddr <= (par - SB'(1)) >> 1;
              state <= (par == '0) ? S_SKW : S_UPR;
            end else state <= S_SKW;
          end
        end
        S_UPR: state <= S_UPD;
        S_SKW: begin
          we_next = 1'b1; waddr <= k; wdata <= cur;
          ws_en_next = 1'b1; ws_id <= cur.tk; ws_val <= k;
          if (!up_mode && !moved && k != '0) begin
            up_mode <= 1'b1; moved <= 1'b1; raddr <= par; state <= S_UPR;
          end else state <= S_HEAD;
        end
        S_HEAD: begin raddr <= '0; state <= S_HEADW; end
        S_HEADW: state <= S_OUT;
        S_OUT: if (!out_valid || !out_stall) begin
          status <= st_r; out_task_id <= oid; out_deadline <= odl;
          head_delay <= (held == '0) ? '0 : 32'($signed(head_gap));
          entry_count <= 7'(held); out_valid_next = 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
    we <= we_next; ws_en <= ws_en_next; set_en <= set_en_next; clr_en <= clr_en_next;
    clear_all <= clear_all_next;
    out_valid <= !rst && out_valid_next;
  end

  `DHTQ_ASSERT_IMP(a_held_cap, 1'b1, held <= CB'(CAPACITY))
  `DHTQ_ASSERT_IMP(a_stall_busy, state != S_IDLE, in_stall)
  `DHTQ_ASSERT_NXT(a_out_after, state == S_OUT && !out_stall, out_valid)
endmodule

### tb/sv/dhtq_checker.sv
// Checker for the timer queue: predicts each result from accepted items and compares
module dhtq_checker import dhtq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [2:0] func,
  input  logic [7:0] task_id,
  input  logic [31:0] deadline,
  input  logic [31:0] now_time,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [2:0] status,
  input  logic [7:0] out_task_id,
  input  logic [31:0] out_deadline,
  input  logic signed [31:0] head_delay,
  input  logic [6:0] entry_count,
  output int fail_count,
  output int pending_count,
  output int result_count
);
  localparam int Cap = 64;

  typedef struct packed {
    logic [2:0]  st;
    logic [7:0]  tid;
    logic [31:0] dl;
    logic [31:0] dly;
    logic [6:0]  cnt;
  } queue_result_t;

  logic [31:0] slot_dl [Cap];
  logic [31:0] slot_seq [Cap];
  logic [7:0]  slot_id [Cap];
  bit          held [256];
  int          where [256];
  int          count;
  logic [31:0] seq_ctr;
  queue_result_t expected_q[$];

  function automatic bit earlier(logic [31:0] da, logic [31:0] sa,
                                 logic [31:0] db, logic [31:0] sb);
    logic [31:0] d;
    logic [31:0] s;
    d = da - db;
    s = sa - sb;
    if (d != 0) return d[31];
    return s[31];
  endfunction

  function automatic void put(int k, logic [31:0] d, logic [31:0] s, logic [7:0] t);
    slot_dl[k] = d;
    slot_seq[k] = s;
    slot_id[k] = t;
    where[t] = k;
  endfunction

  function automatic void sift_up(int k, logic [31:0] d, logic [31:0] s, logic [7:0] t);
    int up;
    while (k > 0) begin
      up = (k - 1) >> 1;
      if (!earlier(d, s, slot_dl[up], slot_seq[up])) break;
      put(k, slot_dl[up], slot_seq[up], slot_id[up]);
      k = up;
    end
    put(k, d, s, t);
  endfunction

  function automatic void sift_down(int k, logic [31:0] d, logic [31:0] s, logic [7:0] t);
    int c;
    while (k < (count >> 1)) begin
      c = (k << 1) + 1;
      if (c + 1 < count &&
          !earlier(slot_dl[c], slot_seq[c], slot_dl[c+1], slot_seq[c+1]))
        c = c + 1;
      if (earlier(d, s, slot_dl[c], slot_seq[c])) break;
      put(k, slot_dl[c], slot_seq[c], slot_id[c]);
      k = c;
    end
    put(k, d, s, t);
  endfunction

  function automatic void take(int i);
    logic [31:0] d;
    logic [31:0] s;
    logic [7:0]  t;
    held[slot_id[i]] = 0;
    count--;
    if (count != i) begin
      d = slot_dl[count];
      s = slot_seq[count];
      t = slot_id[count];
      sift_down(i, d, s, t);
      if (slot_id[i] == t) sift_up(i, d, s, t);
    end
  endfunction

  function automatic queue_result_t apply_item(logic [2:0] f, logic [7:0] id,
                                               logic [31:0] dl, logic [31:0] now);
    queue_result_t r;
    logic [31:0] diff;
    r = '0;
    r.st = ST_OK;
    case (f)
      FUNC_INSERT: begin
        if (held[id]) r.st = ST_DUP;
        else if (count >= Cap) r.st = ST_FULL;
        else begin
          count++;
          held[id] = 1;
          sift_up(count - 1, dl, seq_ctr, id);
          seq_ctr = seq_ctr + 1;
        end
      end
      FUNC_POLL, FUNC_PEEK: begin
        if (count == 0) r.st = ST_EMPTY;
        else begin
          r.tid = slot_id[0];
          r.dl = slot_dl[0];
          if (f == FUNC_POLL) begin
            diff = slot_dl[0] - now;
            if (diff[31] || diff == 0) take(0);
            else r.st = ST_NOT_DUE;
          end
        end
      end
      FUNC_REMOVE: begin
        if (!held[id]) r.st = ST_NOTFOUND;
        else take(where[id]);
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < count; i++) held[slot_id[i]] = 0;
        count = 0;
      end
      default: ;
    endcase
    r.dly = (count != 0) ? slot_dl[0] - now : 32'd0;
    r.cnt = 7'(count);
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t e;
    if (rst) begin
      count = 0;
      seq_ctr = 0;
      foreach (held[i]) held[i] = 0;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(apply_item(func, task_id, deadline, now_time));
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $error("result with no item pending");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (status !== e.st || out_task_id !== e.tid || out_deadline !== e.dl ||
              head_delay !== e.dly || entry_count !== e.cnt) begin
            fail_count <= fail_count + 1;
            if (status !== e.st) $error("status exp %0d got %0d", e.st, status);
            if (out_task_id !== e.tid)
              $error("out_task_id exp %0d got %0d", e.tid, out_task_id);
            if (out_deadline !== e.dl)
              $error("out_deadline exp %h got %h", e.dl, out_deadline);
            if (head_delay !== e.dly)
              $error("head_delay exp %h got %h", e.dly, head_delay);
            if (entry_count !== e.cnt)
              $error("entry_count exp %0d got %0d", e.cnt, entry_count);
          end
        end
      end
    end
    pending_count <= expected_q.size();
  end
endmodule

### tb/sv/tb.sv
// Testbench top: drives timer queue operations and reports the verdict
module tb import dhtq_pkg::*;;
  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] func = FUNC_PEEK;
  logic [7:0] task_id = 0;
  logic [31:0] deadline = 0;
  logic [31:0] now_time = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] status;
  logic [7:0] out_task_id;
  logic [31:0] out_deadline;
  logic signed [31:0] head_delay;
  logic [6:0] entry_count;
  int fail_count, pending_count, result_count;
  bit quiet = 0;
  logic [31:0] clock_now = 0;

  always #4 clk = ~clk;

  deadline_heap_timer_queue_core u_top (.*);

  dhtq_checker u_chk (.*);

  // random stalls on the result side
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 3);
      if (n == 0) begin
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_stall <= 1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end
    end
  end

  task automatic send(logic [2:0] f, logic [7:0] id, logic [31:0] dl, logic [31:0] now);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    task_id <= id;
    deadline <= dl;
    now_time <= now;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly a small id pool so removes and duplicates hit
  function automatic logic [7:0] pick_id();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 79));
  endfunction

  initial begin
    logic [31:0] d;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty cases, extremes, ties, wrap, full, duplicate
    send(FUNC_POLL, 0, 0, 0);
    send(FUNC_PEEK, 0, 0, 32'hFFFF_FFFF);
    send(FUNC_REMOVE, 8'hFF, 0, 0);
    send(FUNC_INSERT, 8'hFF, 32'hFFFF_FFFF, 0);
    send(FUNC_INSERT, 0, 32'h0000_0000, 32'hFFFF_FFF0);
    send(FUNC_INSERT, 8'hAA, 32'h8000_0000, 32'h7FFF_FFFF);
    send(FUNC_INSERT, 8'h55, 32'h8000_0000, 0);
    send(FUNC_INSERT, 8'h55, 5, 0);
    send(FUNC_PEEK, 0, 0, 32'h7FFF_FFFF);
    send(FUNC_POLL, 0, 0, 32'h7FFF_FFF0);
    send(FUNC_POLL, 0, 0, 32'h8000_0000);
    send(FUNC_POLL, 0, 0, 32'h8000_0000);
    send(FUNC_REMOVE, 8'hFF, 0, 0);
    send(3'd5, 1, 1, 1);
    send(3'd7, 1, 1, 1);
    send(3'd6, 1, 1, 1);
    send(FUNC_CLEAR, 0, 0, 0);
    for (int i = 0; i < 66; i++) send(FUNC_INSERT, 8'(i), 32'(i % 3), 0);
    send(FUNC_REMOVE, 8'd10, 0, 0);
    send(FUNC_REMOVE, 8'd10, 0, 0);
    for (int i = 0; i < 8; i++) send(FUNC_POLL, 0, 0, 32'd2);
    send(FUNC_CLEAR, 0, 0, 0);
    // random: deadlines near the moving clock, occasionally anywhere
    for (int n = 0; n < 1000; n++) begin
      int r;
      if (n == 900) quiet = 1;
      r = $urandom_range(0, 99);
      clock_now = clock_now + $urandom_range(0, 40);
      d = ($urandom_range(0, 9) == 0) ? $urandom : clock_now + $urandom_range(0, 300) - 50;
      if (r < 45) send(FUNC_INSERT, pick_id(), d, clock_now);
      else if (r < 70) send(FUNC_POLL, pick_id(), d, clock_now);
      else if (r < 85) send(FUNC_REMOVE, pick_id(), d, clock_now);
      else if (r < 95) send(FUNC_PEEK, pick_id(), d, $urandom);
      else if (r < 97) send(FUNC_CLEAR, pick_id(), d, clock_now);
      else send(3'($urandom_range(5, 7)), pick_id(), d, $urandom);
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("ran directed edge cases and 1000 random queue operations; %0d results checked",
             result_count);
    if (fail_count == 0 && pending_count == 0)
      $display("deadline_heap_timer_queue_core: match");
    else
      $display("deadline_heap_timer_queue_core: mismatch");
    $finish;
  end

  initial begin
    #4000000;
    $display("deadline_heap_timer_queue_core: mismatch");
    $finish;
  end
endmodule
